[src/dfp_pkg.sv]
// ----------------------------------------------------------------------------
// dfp_pkg
// Shared types and constants of the display event frame parser.
// ----------------------------------------------------------------------------
package dfp_pkg;

  localparam logic [7:0]  START_BYTE = 8'hEE;
  localparam logic [31:0] TAIL_MARK  = 32'hFFFC_FFFF;

  // Header bytes that mark a control event report.
  localparam logic [7:0] EVT_HDR1 = 8'hB1;
  localparam logic [7:0] EVT_HDR2 = 8'h11;

  // Control type codes and where their value sits in the frame.
  localparam logic [7:0] TYPE_BYTE9  = 8'h10;
  localparam logic [7:0] TYPE_BYTE8  = 8'h1B;
  localparam logic [7:0] TYPE_WIDE_A = 8'h13;
  localparam logic [7:0] TYPE_WIDE_B = 8'h12;
  localparam logic [7:0] TYPE_WIDE_C = 8'h14;

  // Number of captured frame bytes and the frame position of each slot.
  localparam int NUM_CAPT = 9;
  localparam logic [3:0] CAPT_POS [NUM_CAPT] = '{
    4'd1, 4'd2, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11
  };

  // Slot indexes of the captured bytes.
  localparam int SLOT_HDR1    = 0;
  localparam int SLOT_HDR2    = 1;
  localparam int SLOT_SCREEN  = 2;
  localparam int SLOT_CONTROL = 3;
  localparam int SLOT_TYPE    = 4;
  localparam int SLOT_BYTE8   = 5;
  localparam int SLOT_BYTE9   = 6;
  localparam int SLOT_VAL_HI  = 7;
  localparam int SLOT_VAL_LO  = 8;

  localparam int FRAME_MIN = 5;

  typedef logic [NUM_CAPT-1:0][7:0] dfp_capt_t;

  // Status handed from the frame tracker to the event decoder.
  typedef struct packed {
    logic      frame_end;
    dfp_capt_t capt;
  } dfp_frame_t;

  // One result, as it is loaded into the output register.
  typedef struct packed {
    logic        matched;
    logic [7:0]  screen_id;
    logic [7:0]  control_id;
    logic [7:0]  control_type;
    logic [15:0] value;
  } dfp_result_t;

endpackage

[src/dfp_frame_tracker.sv]
// ----------------------------------------------------------------------------
// dfp_frame_tracker
// Frame position counter, four-byte tail window and captured frame bytes.
// ----------------------------------------------------------------------------
module dfp_frame_tracker #(
  parameter int MAX_FRAME = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output dfp_pkg::dfp_frame_t frame
);

  localparam int PW = $clog2(MAX_FRAME);

  logic [PW-1:0]     pos_r;
  logic [31:0]       tail_r;
  dfp_pkg::dfp_capt_t capt_r;

  logic               active;
  logic [PW:0]        pos_inc;
  logic [31:0]        tail_upd;
  dfp_pkg::dfp_capt_t capt_upd;
  logic               frame_end;
  logic               overflow;

  always_comb begin
    active   = (pos_r != '0) || (rx_byte == dfp_pkg::START_BYTE);
    pos_inc  = {1'b0, pos_r} + (PW+1)'(1);
    tail_upd = {tail_r[23:0], rx_byte};
    for (int i = 0; i < dfp_pkg::NUM_CAPT; i++) begin
      capt_upd[i] = (pos_r == PW'(dfp_pkg::CAPT_POS[i])) ? rx_byte : capt_r[i];
    end
    frame_end = active && (pos_inc > (PW+1)'(dfp_pkg::FRAME_MIN))
                && (tail_upd == dfp_pkg::TAIL_MARK);
    overflow  = active && !frame_end && (pos_inc >= (PW+1)'(MAX_FRAME));
  end

  assign frame.frame_end = frame_end;
  assign frame.capt      = capt_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      tail_r <= '0;
      capt_r <= '0;
    end else if (step && active) begin
      if (frame_end || overflow) begin
        pos_r  <= '0;
        tail_r <= '0;
        capt_r <= '0;
      end else begin
        pos_r  <= pos_inc[PW-1:0];
        tail_r <= tail_upd;
        capt_r <= capt_upd;
      end
    end
  end

endmodule

[src/dfp_event_decode.sv]
// ----------------------------------------------------------------------------
// dfp_event_decode
// Recognises control event reports and keeps the held event fields.
// ----------------------------------------------------------------------------
module dfp_event_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  dfp_pkg::dfp_capt_t   capt,
  output dfp_pkg::dfp_result_t result
);

  logic [7:0]  screen_r;
  logic [7:0]  control_r;
  logic [7:0]  type_r;
  logic [15:0] value_r;

  logic        is_evt;
  logic [7:0]  screen_nxt;
  logic [7:0]  control_nxt;
  logic [7:0]  type_nxt;
  logic [15:0] value_nxt;
  logic [7:0]  evt_type;

  always_comb begin
    is_evt = (capt[dfp_pkg::SLOT_HDR1] == dfp_pkg::EVT_HDR1)
             && (capt[dfp_pkg::SLOT_HDR2] == dfp_pkg::EVT_HDR2);
    evt_type    = capt[dfp_pkg::SLOT_TYPE];
    screen_nxt  = screen_r;
    control_nxt = control_r;
    type_nxt    = type_r;
    value_nxt   = value_r;
    if (is_evt) begin
      screen_nxt  = capt[dfp_pkg::SLOT_SCREEN];
      control_nxt = capt[dfp_pkg::SLOT_CONTROL];
      type_nxt    = evt_type;
      case (evt_type) inside
        dfp_pkg::TYPE_BYTE9: value_nxt = {8'h00, capt[dfp_pkg::SLOT_BYTE9]};
        dfp_pkg::TYPE_BYTE8: value_nxt = {8'h00, capt[dfp_pkg::SLOT_BYTE8]};
        dfp_pkg::TYPE_WIDE_A, dfp_pkg::TYPE_WIDE_B, dfp_pkg::TYPE_WIDE_C: begin
          value_nxt = {capt[dfp_pkg::SLOT_VAL_HI], capt[dfp_pkg::SLOT_VAL_LO]};
        end
        default: value_nxt = value_r;
      endcase
    end
  end

  assign result.matched      = is_evt;
  assign result.screen_id    = screen_nxt;
  assign result.control_id   = control_nxt;
  assign result.control_type = type_nxt;
  assign result.value        = value_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_r  <= '0;
      control_r <= '0;
      type_r    <= '0;
      value_r   <= '0;
    end else if (fire) begin
      screen_r  <= screen_nxt;
      control_r <= control_nxt;
      type_r    <= type_nxt;
      value_r   <= value_nxt;
    end
  end

endmodule

[src/display_event_frame_parser.sv]
// ----------------------------------------------------------------------------
// display_event_frame_parser
// Frame parser for a serial display link: finds control event reports.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                                   Direction  Meaning
//   in       in_valid, in_stall, in_rx_byte           in         one received byte
//   out      out_valid, out_stall, out_matched,       out        one result per
//            out_screen_id, out_control_id,                      completed frame
//            out_control_type, out_value
//
// A byte is taken into the input register in the cycle its request is
// accepted and is parsed in the cycle it moves on; the result of a
// completed frame is then held in the output register. One byte can be
// accepted in every cycle while no stalled result holds the pipeline.
// Reset (rst_n low, synchronous) returns the parser to idle and clears the
// held event fields. A stalled result holds the pipeline: the input register
// keeps its byte and in_stall rises until the result has been taken.
//
module display_event_frame_parser #(
  parameter int MAX_FRAME = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_matched,
  output logic [7:0]  out_screen_id,
  output logic [7:0]  out_control_id,
  output logic [7:0]  out_control_type,
  output logic [15:0] out_value
);

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // Output register.
  logic                 out_valid_r;
  dfp_pkg::dfp_result_t out_r;

  logic                 advance;
  logic                 step;
  logic                 fire;
  dfp_pkg::dfp_frame_t  frame;
  dfp_pkg::dfp_result_t result;

  // The pipeline moves whenever the output register is free or being emptied.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  // The byte in the input register is parsed in the cycle it moves on.
  assign step     = s1_valid_r && advance;
  assign fire     = step && frame.frame_end;

  dfp_frame_tracker #(
    .MAX_FRAME(MAX_FRAME)
  ) u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .rx_byte(s1_byte_r),
    .frame  (frame)
  );

  dfp_event_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .capt  (frame.capt),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire;
    end
  end

  // Payload is loaded only with a result, so a waiting result never changes.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_matched      = out_r.matched;
  assign out_screen_id    = out_r.screen_id;
  assign out_control_id   = out_r.control_id;
  assign out_control_type = out_r.control_type;
  assign out_value        = out_r.value;

endmodule

[verif/frame_event_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_event_checker
// Watches both channels of the frame parser, predicts each frame report from
// the accepted byte stream and compares every result field by field.
// ----------------------------------------------------------------------------
module frame_event_checker #(
  parameter int MAX_FRAME = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_matched,
  input  logic [7:0]  out_screen_id,
  input  logic [7:0]  out_control_id,
  input  logic [7:0]  out_control_type,
  input  logic [15:0] out_value,
  output int          mismatch_count,
  output int          reports_pending
);

  typedef struct packed {
    logic        matched;
    logic [7:0]  screen;
    logic [7:0]  control;
    logic [7:0]  ctype;
    logic [15:0] value;
  } event_report_t;

  int            frame_pos = 0;
  logic [31:0]   tail_bytes = '0;
  logic [7:0]    capt [dfp_pkg::NUM_CAPT];
  logic [7:0]    held_screen = '0;
  logic [7:0]    held_control = '0;
  logic [7:0]    held_type = '0;
  logic [15:0]   held_value = '0;
  event_report_t report_q [$];
  int            fail_tally = 0;
  int            waiting = 0;

  assign mismatch_count  = fail_tally;
  assign reports_pending = waiting;

  initial begin
    foreach (capt[i]) capt[i] = '0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_tally++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    end
  endtask

  function automatic int capture_slot(input int pos);
    case (pos)
      1:       return dfp_pkg::SLOT_HDR1;
      2:       return dfp_pkg::SLOT_HDR2;
      4:       return dfp_pkg::SLOT_SCREEN;
      6:       return dfp_pkg::SLOT_CONTROL;
      7:       return dfp_pkg::SLOT_TYPE;
      8:       return dfp_pkg::SLOT_BYTE8;
      9:       return dfp_pkg::SLOT_BYTE9;
      10:      return dfp_pkg::SLOT_VAL_HI;
      11:      return dfp_pkg::SLOT_VAL_LO;
      default: return -1;
    endcase
  endfunction

  function automatic void clear_frame();
    frame_pos  = 0;
    tail_bytes = '0;
    foreach (capt[i]) capt[i] = '0;
  endfunction

  // Advances the frame state by one byte; returns 1 when a frame report is due.
  function automatic bit track_frame_byte(input logic [7:0] b, output event_report_t rep);
    int slot;
    rep = '0;
    if (frame_pos == 0 && b != dfp_pkg::START_BYTE) return 1'b0;
    slot = capture_slot(frame_pos);
    if (slot >= 0) capt[slot] = b;
    tail_bytes = {tail_bytes[23:0], b};
    frame_pos++;
    if (frame_pos > dfp_pkg::FRAME_MIN && tail_bytes == dfp_pkg::TAIL_MARK) begin
      rep.matched = (capt[dfp_pkg::SLOT_HDR1] == dfp_pkg::EVT_HDR1)
                    && (capt[dfp_pkg::SLOT_HDR2] == dfp_pkg::EVT_HDR2);
      if (rep.matched) begin
        held_screen  = capt[dfp_pkg::SLOT_SCREEN];
        held_control = capt[dfp_pkg::SLOT_CONTROL];
        held_type    = capt[dfp_pkg::SLOT_TYPE];
        case (capt[dfp_pkg::SLOT_TYPE]) inside
          dfp_pkg::TYPE_BYTE9: held_value = {8'h00, capt[dfp_pkg::SLOT_BYTE9]};
          dfp_pkg::TYPE_BYTE8: held_value = {8'h00, capt[dfp_pkg::SLOT_BYTE8]};
          dfp_pkg::TYPE_WIDE_A, dfp_pkg::TYPE_WIDE_B, dfp_pkg::TYPE_WIDE_C: begin
            held_value = {capt[dfp_pkg::SLOT_VAL_HI], capt[dfp_pkg::SLOT_VAL_LO]};
          end
          default: ;
        endcase
      end
      rep.screen  = held_screen;
      rep.control = held_control;
      rep.ctype   = held_type;
      rep.value   = held_value;
      clear_frame();
      return 1'b1;
    end
    if (frame_pos >= MAX_FRAME) clear_frame();
    return 1'b0;
  endfunction

  // A result can never leave in the cycle its last byte is taken, so the
  // result side is checked before the new byte is predicted.
  always @(posedge clk) begin : watch_channels
    event_report_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          report_mismatch($sformatf("result with no report expected, value %h", out_value));
        end else begin
          want = report_q.pop_front();
          check_field("matched", 16'(out_matched), 16'(want.matched));
          check_field("screen_id", 16'(out_screen_id), 16'(want.screen));
          check_field("control_id", 16'(out_control_id), 16'(want.control));
          check_field("control_type", 16'(out_control_type), 16'(want.ctype));
          check_field("value", out_value, want.value);
        end
      end
      if (in_valid && !in_stall) begin
        if (track_frame_byte(in_rx_byte, want)) report_q.push_back(want);
      end
      waiting = report_q.size();
    end
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives byte requests into the display event frame parser and takes its
// frame reports, with random idling on both sides, a long result hold-off and
// frames both well formed and broken; a checker beside the block predicts and
// compares every report, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_FRAME    = 256;
  // Longest quiet stretch that a correct run can show is the result hold-off
  // plus a few random gaps; this is many times that.
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_rx_byte = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_matched;
  logic [7:0]  out_screen_id;
  logic [7:0]  out_control_id;
  logic [7:0]  out_control_type;
  logic [15:0] out_value;

  int mismatch_count;
  int reports_pending;

  // Idling rates in percent, set per phase by the stimulus.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // The stimulus asks for a hold-off by bumping holds_asked; the receiver
  // notices the difference and counts the hold-off down in its own process.
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;

  int frame_bytes_sent = 0;
  int reports_seen = 0;
  int quiet_cycles = 0;

  // Bytes of the next stretch of traffic, built up before being sent.
  logic [7:0] frame_buf [$];

  always #10 clk = ~clk;

  display_event_frame_parser #(.MAX_FRAME(MAX_FRAME)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_matched(out_matched),
    .out_screen_id(out_screen_id), .out_control_id(out_control_id),
    .out_control_type(out_control_type), .out_value(out_value)
  );

  frame_event_checker #(.MAX_FRAME(MAX_FRAME)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_matched(out_matched),
    .out_screen_id(out_screen_id), .out_control_id(out_control_id),
    .out_control_type(out_control_type), .out_value(out_value),
    .mismatch_count(mismatch_count), .reports_pending(reports_pending)
  );

  // The receiver stalls at the phase's random rate, or solidly during a
  // requested hold-off, so that the parser fills up and stalls its input.
  always @(posedge clk) begin : result_receiver
    if (holds_done != holds_asked) begin
      holds_done = holds_asked;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Counts the results taken, and ends the run if neither channel moves for
  // far longer than any correct run would allow.
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if (out_valid && !out_stall) reports_seen++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Byte values lean towards the extremes so that every bit is seen at both
  // levels and the all-ones tail pattern turns up inside data now and then.
  function automatic logic [7:0] any_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Offers one request, idling first at the phase's rate, and returns at the
  // clock edge at which it is accepted. Valid is only lowered in a gap, so a
  // back-to-back request keeps it high without a second assignment.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_frame_buf(input bit counted);
    while (frame_buf.size() > 0) begin
      send_byte(frame_buf.pop_front());
      if (counted) frame_bytes_sent++;
    end
  endtask

  // Stops offering and waits until every expected report has been taken. The
  // first edge lets the checker record the last byte before it is asked.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (reports_pending == 0);
  endtask

  task automatic add_tail();
    frame_buf.push_back(dfp_pkg::TAIL_MARK[31:24]);
    frame_buf.push_back(dfp_pkg::TAIL_MARK[23:16]);
    frame_buf.push_back(dfp_pkg::TAIL_MARK[15:8]);
    frame_buf.push_back(dfp_pkg::TAIL_MARK[7:0]);
  endtask

  // A full control event report with a random type, now and then padded
  // and now and then carrying a near miss of the end mark before the real one.
  task automatic add_event_frame();
    logic [7:0] kind;
    case ($urandom_range(6))
      0:       kind = dfp_pkg::TYPE_BYTE9;
      1:       kind = dfp_pkg::TYPE_BYTE8;
      2:       kind = dfp_pkg::TYPE_WIDE_A;
      3:       kind = dfp_pkg::TYPE_WIDE_B;
      4:       kind = dfp_pkg::TYPE_WIDE_C;
      default: kind = any_byte();
    endcase
    frame_buf.push_back(dfp_pkg::START_BYTE);
    frame_buf.push_back(dfp_pkg::EVT_HDR1);
    frame_buf.push_back(dfp_pkg::EVT_HDR2);
    repeat (4) frame_buf.push_back(any_byte());
    frame_buf.push_back(kind);
    repeat ($urandom_range(4, 7)) frame_buf.push_back(any_byte());
    if ($urandom_range(5) == 0) begin
      frame_buf.push_back(dfp_pkg::TAIL_MARK[31:24]);
      frame_buf.push_back(dfp_pkg::TAIL_MARK[23:16]);
      frame_buf.push_back(dfp_pkg::TAIL_MARK[15:8]);
      frame_buf.push_back(8'($urandom_range(254)));
    end
    add_tail();
  endtask

  // A frame that is mostly not an event report, often with just one header byte right.
  task automatic add_foreign_frame();
    frame_buf.push_back(dfp_pkg::START_BYTE);
    frame_buf.push_back($urandom_range(1) ? dfp_pkg::EVT_HDR1 : any_byte());
    frame_buf.push_back($urandom_range(1) ? any_byte() : dfp_pkg::EVT_HDR2);
    repeat ($urandom_range(3, 12)) frame_buf.push_back(any_byte());
    add_tail();
  endtask

  // A short frame that often ends before all captured positions arrive. With
  // no header and no body the end mark falls within the first five bytes and
  // must not count, so the frame runs on into whatever follows.
  task automatic add_short_frame();
    frame_buf.push_back(dfp_pkg::START_BYTE);
    if ($urandom_range(1)) begin
      frame_buf.push_back(dfp_pkg::EVT_HDR1);
      frame_buf.push_back(dfp_pkg::EVT_HDR2);
    end
    repeat ($urandom_range(0, 6)) frame_buf.push_back(any_byte());
    add_tail();
  endtask

  // Line noise between frames; the start byte is kept out of it.
  task automatic add_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 4)) begin
      b = any_byte();
      frame_buf.push_back(b == dfp_pkg::START_BYTE ? ~b : b);
    end
  endtask

  // A frame of exactly MAX_FRAME bytes: either dropped for want of an end
  // mark, or closed by an end mark whose last byte is the MAX_FRAME-th.
  task automatic add_long_frame(input bit closed);
    frame_buf.push_back(dfp_pkg::START_BYTE);
    repeat (closed ? MAX_FRAME - 5 : MAX_FRAME - 1) begin
      frame_buf.push_back(8'($urandom_range(254)));
    end
    if (closed) add_tail();
  endtask

  task automatic run_random(input int byte_goal, input int report_goal);
    int pick;
    while (frame_bytes_sent < byte_goal || reports_seen < report_goal) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        add_event_frame();
      end else if (pick < 65) begin
        add_foreign_frame();
      end else if (pick < 80) begin
        add_short_frame();
      end
      if (pick >= 80) begin
        add_noise();
        send_frame_buf(1'b0);
      end else begin
        send_frame_buf(1'b1);
      end
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: the sender idles rarely, the receiver often.
    send_idle_pct = 7;
    recv_idle_pct = 71;

    // Directed opening: both extreme bytes while idle, which are ignored; a
    // short event report whose type and value positions never arrive; then a
    // full report of a wide-value type with a start byte inside its body and
    // extreme bytes in every field.
    frame_buf = '{8'h00, 8'hFF};
    send_frame_buf(1'b0);
    frame_buf = '{dfp_pkg::START_BYTE, dfp_pkg::EVT_HDR1, dfp_pkg::EVT_HDR2};
    add_tail();
    frame_buf.push_back(dfp_pkg::START_BYTE);
    frame_buf.push_back(dfp_pkg::EVT_HDR1);
    frame_buf.push_back(dfp_pkg::EVT_HDR2);
    frame_buf.push_back(dfp_pkg::START_BYTE);
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(dfp_pkg::TYPE_WIDE_A);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(8'h00);
    add_tail();
    send_frame_buf(1'b1);
    drain();

    // Result hold-off: the receiver stops taking reports while minimal frames
    // keep coming, so the parser fills up and must stall its input. The
    // sender then pauses until every report has been taken.
    holds_asked++;
    repeat (8) begin
      frame_buf.push_back(dfp_pkg::START_BYTE);
      frame_buf.push_back(any_byte());
      add_tail();
    end
    send_frame_buf(1'b1);
    drain();

    run_random(250, 14);
    drain();

    // Phase two: the roles are swapped.
    send_idle_pct = 71;
    recv_idle_pct = 7;
    run_random(420, 28);
    drain();

    // Phase three: no idling on either side, and the frames that reach the
    // length limit, one dropped and one ending right at it.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_long_frame(1'b0);
    add_event_frame();
    add_long_frame(1'b1);
    send_frame_buf(1'b1);
    run_random(950, 42);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
src/dfp_pkg.sv
src/dfp_frame_tracker.sv
src/dfp_event_decode.sv
src/display_event_frame_parser.sv
verif/frame_event_checker.sv
verif/tb_top.sv
